// ----- hdl/tsdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiered speed differential drive package
// Shared types, register indexes, reset values, tier constants and the
// saturation helper used by the drive datapath.
// ----------------------------------------------------------------------------
package tsdd_pkg;

	localparam int unsigned CfgIndexWidth = 3;

	localparam logic [CfgIndexWidth-1:0] REG_STRAIGHT_LEVEL = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_MEDIUM_LEVEL   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_TURN_LEVEL     = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_BRAKE_LEVEL    = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_STRAIGHT_CUT   = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_MEDIUM_CUT     = 3'd5;

	localparam logic signed [7:0] STRAIGHT_LEVEL_RST = 8'sd70;
	localparam logic signed [7:0] MEDIUM_LEVEL_RST   = 8'sd55;
	localparam logic signed [7:0] TURN_LEVEL_RST     = 8'sd51;
	localparam logic signed [7:0] BRAKE_LEVEL_RST    = -8'sd45;
	localparam logic [6:0]        STRAIGHT_CUT_RST   = 7'd10;
	localparam logic [6:0]        MEDIUM_CUT_RST     = 7'd30;

	localparam logic [5:0] CNT_MAX   = 6'd42;
	localparam logic [5:0] CNT_LONG  = 6'd15;
	localparam logic [5:0] CNT_BRAKE = 6'd8;

	localparam logic signed [8:0] LONG_DROP   = 9'sd6;
	localparam logic signed [9:0] INNER_DROP  = 10'sd2;
	localparam logic signed [9:0] OUTER_BOOST = 10'sd5;

	localparam logic [1:0] SLOPE_DOWN = 2'b11;
	localparam logic [1:0] SLOPE_UP   = 2'b01;

	typedef struct packed {
		logic signed [7:0] straight_level;
		logic signed [7:0] medium_level;
		logic signed [7:0] turn_level;
		logic signed [7:0] brake_level;
		logic [6:0]        straight_cut;
		logic [6:0]        medium_cut;
	} cfg_t;

	function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
		logic signed [7:0] r;
		if (v > 10'sd127) begin
			r = 8'sd127;
		end else if (v < -10'sd128) begin
			r = -8'sd128;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/tsdd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Tiered speed differential drive configuration registers
// Holds the speed tiers and the turn thresholds written through the
// configuration channel. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tsdd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsdd_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [7:0]                          cfg_data,
	output tsdd_pkg::cfg_t                      cfg
);

	tsdd_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.straight_level <= tsdd_pkg::STRAIGHT_LEVEL_RST;
			cfg_q.medium_level   <= tsdd_pkg::MEDIUM_LEVEL_RST;
			cfg_q.turn_level     <= tsdd_pkg::TURN_LEVEL_RST;
			cfg_q.brake_level    <= tsdd_pkg::BRAKE_LEVEL_RST;
			cfg_q.straight_cut   <= tsdd_pkg::STRAIGHT_CUT_RST;
			cfg_q.medium_cut     <= tsdd_pkg::MEDIUM_CUT_RST;
		end else if (wr_en) begin
			unique case (cfg_index)
				tsdd_pkg::REG_STRAIGHT_LEVEL: cfg_q.straight_level <= cfg_data;
				tsdd_pkg::REG_MEDIUM_LEVEL:   cfg_q.medium_level   <= cfg_data;
				tsdd_pkg::REG_TURN_LEVEL:     cfg_q.turn_level     <= cfg_data;
				tsdd_pkg::REG_BRAKE_LEVEL:    cfg_q.brake_level    <= cfg_data;
				tsdd_pkg::REG_STRAIGHT_CUT:   cfg_q.straight_cut   <= cfg_data[6:0];
				tsdd_pkg::REG_MEDIUM_CUT:     cfg_q.medium_cut     <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/tsdd_tier.sv -----
// ----------------------------------------------------------------------------
// Tiered speed differential drive tier selection
// Keeps the straightness counter and picks the tier speed for the current
// steering command, with the ramp override applied last.
// ----------------------------------------------------------------------------
module tsdd_tier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic signed [7:0]   steer,
	input  logic [1:0]          slope,
	input  tsdd_pkg::cfg_t      cfg,
	output logic signed [8:0]   speed
);

	logic [5:0]        count_q;
	logic [5:0]        count_nxt;
	logic [7:0]        mag;
	logic              is_straight;
	logic              is_moderate;
	logic signed [8:0] straight9;
	logic signed [8:0] tier_speed;

	assign mag         = steer[7] ? 8'(-steer) : 8'(steer);
	assign is_straight = mag < {1'b0, cfg.straight_cut};
	assign is_moderate = mag < {1'b0, cfg.medium_cut};
	assign straight9   = 9'(cfg.straight_level);

	always_comb begin
		count_nxt  = count_q;
		tier_speed = straight9;
		priority if (is_straight) begin
			count_nxt  = (count_q < tsdd_pkg::CNT_MAX) ? count_q + 6'd1 : count_q;
			tier_speed = (count_nxt > tsdd_pkg::CNT_LONG) ?
				straight9 - tsdd_pkg::LONG_DROP : straight9;
		end else if (count_q > tsdd_pkg::CNT_BRAKE) begin
			if (is_moderate) begin
				count_nxt  = count_q - 6'd1;
				tier_speed = 9'sd0;
			end else begin
				count_nxt  = count_q - 6'd2;
				tier_speed = 9'(cfg.brake_level);
			end
		end else begin
			count_nxt  = 6'd0;
			tier_speed = is_moderate ? 9'(cfg.medium_level) : 9'(cfg.turn_level);
		end
	end

	always_comb begin
		unique case (slope)
			tsdd_pkg::SLOPE_DOWN: speed = 9'(cfg.brake_level);
			tsdd_pkg::SLOPE_UP:   speed = straight9;
			default:              speed = tier_speed;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 6'd0;
		end else if (advance) begin
			count_q <= count_nxt;
		end
	end

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tsdd_pkg::CNT_MAX)
		else $error("straight counter above its ceiling");

	a_curve_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_straight && (count_q <= tsdd_pkg::CNT_BRAKE) |=> count_q == 6'd0)
		else $error("short straight followed by a curve did not clear the counter");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count_q))
		else $error("straight counter moved without a transaction");
`endif

endmodule

// ----- hdl/tsdd_diff.sv -----
// ----------------------------------------------------------------------------
// Tiered speed differential drive wheel split
// Applies the inner and outer wheel offsets outside the middle steering band
// and saturates the base and wheel speeds to eight bits.
// ----------------------------------------------------------------------------
module tsdd_diff (
	input  logic signed [7:0] steer,
	input  logic [6:0]        medium_cut,
	input  logic signed [8:0] speed,
	output logic signed [7:0] base_speed,
	output logic signed [7:0] left_speed,
	output logic signed [7:0] right_speed
);

	logic signed [8:0] steer9;
	logic signed [8:0] cut9;
	logic signed [9:0] speed10;
	logic signed [9:0] left10;
	logic signed [9:0] right10;

	assign steer9  = 9'(steer);
	assign cut9    = $signed({2'b00, medium_cut});
	assign speed10 = 10'(speed);

	always_comb begin
		priority if (steer9 < -cut9) begin
			left10  = speed10 - tsdd_pkg::INNER_DROP;
			right10 = speed10 + tsdd_pkg::OUTER_BOOST;
		end else if (steer9 > cut9) begin
			left10  = speed10 + tsdd_pkg::OUTER_BOOST;
			right10 = speed10 - tsdd_pkg::INNER_DROP;
		end else begin
			left10  = speed10;
			right10 = speed10;
		end
	end

	assign base_speed  = tsdd_pkg::sat8(speed10);
	assign left_speed  = tsdd_pkg::sat8(left10);
	assign right_speed = tsdd_pkg::sat8(right10);

endmodule

// ----- hdl/tiered_speed_differential_drive.sv -----
// ----------------------------------------------------------------------------
// Tiered speed differential drive
// Turns one steering command and ramp flag per control tick into the servo
// angle, a tiered base speed and the left and right wheel speeds.
// ----------------------------------------------------------------------------
// Each transaction is registered at the input, resolved by compare and add
// logic together with the straightness counter, and held in the output
// register until taken, so one item is accepted per cycle unless
// in_stall is raised. The input side stalls only while the output
// register is full, stalled, and a second item already waits in
// the input register. Configuration writes are always ready and take effect on
// the next transaction; write them only while no transaction is in flight.
module tiered_speed_differential_drive (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [7:0]                   steer,
	input  logic signed [1:0]                   slope,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [7:0]                   servo_angle,
	output logic signed [7:0]                   base_speed,
	output logic signed [7:0]                   left_speed,
	output logic signed [7:0]                   right_speed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsdd_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [7:0]                          cfg_data
);

	tsdd_pkg::cfg_t    cfg;
	logic              valid_s1;
	logic signed [7:0] steer_s1;
	logic [1:0]        slope_s1;
	logic              out_valid_q;
	logic signed [7:0] servo_q;
	logic signed [7:0] base_q;
	logic signed [7:0] left_q;
	logic signed [7:0] right_q;
	logic              out_open;
	logic              advance;
	logic              in_take;
	logic signed [8:0] speed;
	logic signed [7:0] base_c;
	logic signed [7:0] left_c;
	logic signed [7:0] right_c;

	assign out_open = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_open;
	assign in_stall = valid_s1 && !out_open;
	assign in_take  = in_valid && !in_stall;

	tsdd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsdd_tier u_tier (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.steer   (steer_s1),
		.slope   (slope_s1),
		.cfg     (cfg),
		.speed   (speed)
	);

	tsdd_diff u_diff (
		.steer       (steer_s1),
		.medium_cut  (cfg.medium_cut),
		.speed       (speed),
		.base_speed  (base_c),
		.left_speed  (left_c),
		.right_speed (right_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			steer_s1 <= steer;
			slope_s1 <= slope;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			servo_q <= steer_s1;
			base_q  <= base_c;
			left_q  <= left_c;
			right_q <= right_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign servo_angle = servo_q;
	assign base_speed  = base_q;
	assign left_speed  = left_q;
	assign right_speed = right_q;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled while the pipeline had room");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_open |=> out_valid_q)
		else $error("transaction lost between input and output register");

	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !valid_s1 |=> !out_valid_q)
		else $error("result repeated after it was taken");
`endif

endmodule
